FILE: hw/rtl/mfsp_pkg.sv
// Shared types, codes and signature tables for the MIDI file stream parser.
package mfsp_pkg;

  typedef enum logic [12:0] {
    PH_HSIG  = 13'b0000000000001,
    PH_HLEN  = 13'b0000000000010,
    PH_HFMT  = 13'b0000000000100,
    PH_HTRK  = 13'b0000000001000,
    PH_HDIV  = 13'b0000000010000,
    PH_TSIG  = 13'b0000000100000,
    PH_TLEN  = 13'b0000001000000,
    PH_DELTA = 13'b0000010000000,
    PH_STAT  = 13'b0000100000000,
    PH_META  = 13'b0001000000000,
    PH_LEN   = 13'b0010000000000,
    PH_DATA  = 13'b0100000000000,
    PH_ERR   = 13'b1000000000000
  } phase_t;

  localparam logic [3:0] TK_HLEN   = 4'd0;
  localparam logic [3:0] TK_FMT    = 4'd1;
  localparam logic [3:0] TK_TRKS   = 4'd2;
  localparam logic [3:0] TK_DIV    = 4'd3;
  localparam logic [3:0] TK_TLEN   = 4'd4;
  localparam logic [3:0] TK_DELTA  = 4'd5;
  localparam logic [3:0] TK_STATUS = 4'd6;
  localparam logic [3:0] TK_META   = 4'd7;
  localparam logic [3:0] TK_DLEN   = 4'd8;
  localparam logic [3:0] TK_DATA   = 4'd9;
  localparam logic [3:0] TK_ERROR  = 4'd10;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HDR_SIG   = 3'd1;
  localparam logic [2:0] ERR_TRK_SIG   = 3'd2;
  localparam logic [2:0] ERR_STATUS    = 3'd3;
  localparam logic [2:0] ERR_EOT       = 3'd4;
  localparam logic [2:0] ERR_VLV       = 3'd5;
  localparam logic [2:0] ERR_TRUNCATED = 3'd6;

  localparam logic [7:0] META_EOT = 8'h2F;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [7:0]  status;
    logic [7:0]  meta;
    logic        last;
    logic [2:0]  err;
  } token_t;

  // "MThd" for the header, "MTrk" for a track
  function automatic logic [7:0] sig_byte(input logic is_track, input logic [1:0] idx);
    logic [7:0] res;
    case (idx)
      2'd0: res = 8'h4D;
      2'd1: res = 8'h54;
      2'd2: res = is_track ? 8'h72 : 8'h68;
      default: res = is_track ? 8'h6B : 8'h64;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/mfsp_parse.sv
// Parser state and per-byte next-state and token logic.
module mfsp_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      data_byte,
  input  logic            end_of_file,
  output logic            emit,
  output mfsp_pkg::token_t tok
);
  import mfsp_pkg::*;

  phase_t      phase, ph_next;
  logic [2:0]  fbc, fbc_next;
  logic [31:0] acc, acc_next;
  logic [31:0] tbl, tbl_next;
  logic [27:0] dbl, dbl_next;
  logic [7:0]  stat, stat_next;
  logic [7:0]  meta, meta_next;

  logic [2:0]  err;
  logic        clean;
  logic        done_ev;
  logic        tok_emit;
  logic [3:0]  tok_kind;
  logic [31:0] tok_value;
  logic        tok_last;
  logic [31:0] fld_shift;
  logic [31:0] vlv_shift;
  logic [2:0]  fbc_inc;
  logic        fld_done;
  logic [27:0] dbl_dec;
  logic        in_event;

  assign fld_shift = {acc[23:0], data_byte};
  assign vlv_shift = {acc[24:0], data_byte[6:0]};
  assign fbc_inc   = fbc + 3'd1;
  assign dbl_dec   = (dbl != 28'd0) ? dbl - 28'd1 : 28'd0;
  assign in_event  = (phase == PH_DELTA) || (phase == PH_STAT) || (phase == PH_META) ||
                     (phase == PH_LEN) || (phase == PH_DATA);
  assign fld_done  = ((phase == PH_HLEN) || (phase == PH_TLEN)) ? (fbc == 3'd3)
                                                                : (fbc != 3'd0);

  always_comb begin
    ph_next   = phase;
    fbc_next  = fbc;
    acc_next  = acc;
    tbl_next  = tbl;
    dbl_next  = dbl;
    stat_next = stat;
    meta_next = meta;
    err       = ERR_NONE;
    clean     = 1'b0;
    done_ev   = 1'b0;
    tok_emit  = 1'b0;
    tok_kind  = TK_ERROR;
    tok_value = {24'd0, data_byte};
    tok_last  = 1'b0;

    if (in_event && tbl != 32'd0) tbl_next = tbl - 32'd1;

    unique case (phase)
      PH_HSIG, PH_TSIG: begin
        if (data_byte != sig_byte(phase == PH_TSIG, fbc[1:0])) begin
          err = (phase == PH_HSIG) ? ERR_HDR_SIG : ERR_TRK_SIG;
        end else if (fbc == 3'd3) begin
          fbc_next = 3'd0;
          acc_next = 32'd0;
          ph_next  = (phase == PH_HSIG) ? PH_HLEN : PH_TLEN;
        end else begin
          fbc_next = fbc_inc;
        end
      end
      PH_HLEN, PH_HFMT, PH_HTRK, PH_HDIV, PH_TLEN: begin
        acc_next = fld_shift;
        fbc_next = fbc_inc;
        if (fld_done) begin
          fbc_next  = 3'd0;
          acc_next  = 32'd0;
          tok_emit  = 1'b1;
          tok_value = fld_shift;
          unique case (phase)
            PH_HLEN: begin
              tok_kind = TK_HLEN;
              ph_next  = PH_HFMT;
            end
            PH_HFMT: begin
              tok_kind = TK_FMT;
              ph_next  = PH_HTRK;
            end
            PH_HTRK: begin
              tok_kind = TK_TRKS;
              ph_next  = PH_HDIV;
            end
            PH_HDIV: begin
              tok_kind = TK_DIV;
              ph_next  = PH_TSIG;
              clean    = 1'b1;
            end
            default: begin
              tok_kind  = TK_TLEN;
              tbl_next  = fld_shift;
              stat_next = 8'd0;
              meta_next = 8'd0;
              if (fld_shift == 32'd0) begin
                ph_next = PH_TSIG;
                clean   = 1'b1;
              end else begin
                ph_next = PH_DELTA;
              end
            end
          endcase
        end
      end
      PH_DELTA, PH_LEN: begin
        if (phase == PH_DELTA && fbc == 3'd0) begin
          stat_next = 8'd0;
          meta_next = 8'd0;
        end
        if (data_byte[7]) begin
          acc_next = vlv_shift;
          fbc_next = fbc_inc;
          if (fbc_inc >= 3'd4) err = ERR_VLV;
        end else begin
          acc_next  = 32'd0;
          fbc_next  = 3'd0;
          tok_emit  = 1'b1;
          tok_value = vlv_shift;
          if (phase == PH_DELTA) begin
            tok_kind = TK_DELTA;
            ph_next  = PH_STAT;
          end else if (vlv_shift == 32'd0) begin
            tok_kind = TK_DLEN;
            tok_last = 1'b1;
            done_ev  = 1'b1;
          end else begin
            tok_kind = TK_DLEN;
            dbl_next = vlv_shift[27:0];
            ph_next  = PH_DATA;
          end
        end
      end
      PH_STAT: begin
        if (!data_byte[7]) begin
          err = ERR_STATUS;
        end else begin
          stat_next = data_byte;
          tok_emit  = 1'b1;
          tok_kind  = TK_STATUS;
          if (data_byte == 8'hFF) begin
            ph_next = PH_META;
          end else if (data_byte[7:4] == 4'hF) begin
            ph_next = PH_LEN;
          end else begin
            dbl_next = (data_byte[7:5] == 3'b110) ? 28'd1 : 28'd2;
            ph_next  = PH_DATA;
          end
        end
      end
      PH_META: begin
        meta_next = data_byte;
        if (data_byte == META_EOT && tbl_next != 32'd1) begin
          err = ERR_EOT;
        end else begin
          tok_emit = 1'b1;
          tok_kind = TK_META;
          ph_next  = PH_LEN;
        end
      end
      PH_DATA: begin
        dbl_next = dbl_dec;
        tok_emit = 1'b1;
        tok_kind = TK_DATA;
        if (dbl_dec == 28'd0) begin
          tok_last = 1'b1;
          done_ev  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (done_ev) begin
      if (tbl_next == 32'd0) begin
        ph_next = PH_TSIG;
        clean   = 1'b1;
      end else begin
        ph_next = PH_DELTA;
      end
    end

    tok.err = ERR_NONE;
    if (err != ERR_NONE) begin
      tok_emit  = 1'b1;
      tok_kind  = TK_ERROR;
      tok_value = {24'd0, data_byte};
      tok_last  = 1'b0;
      tok.err   = err;
      ph_next   = PH_ERR;
    end else if (end_of_file && ph_next != PH_ERR && !clean) begin
      tok_emit  = 1'b1;
      tok_kind  = TK_ERROR;
      tok_value = {24'd0, data_byte};
      tok_last  = 1'b0;
      tok.err   = ERR_TRUNCATED;
    end

    emit       = tok_emit;
    tok.kind   = tok_kind;
    tok.value  = tok_value;
    tok.status = stat_next;
    tok.meta   = meta_next;
    tok.last   = tok_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_file)) begin
      phase <= PH_HSIG;
      fbc   <= 3'd0;
      acc   <= 32'd0;
      tbl   <= 32'd0;
      dbl   <= 28'd0;
      stat  <= 8'd0;
      meta  <= 8'd0;
    end else if (step) begin
      phase <= ph_next;
      fbc   <= fbc_next;
      acc   <= acc_next;
      tbl   <= tbl_next;
      dbl   <= dbl_next;
      stat  <= stat_next;
      meta  <= meta_next;
    end
  end

endmodule

FILE: hw/rtl/midi_file_stream_parser_unit.sv
// Top level of the MIDI file stream parser: input register, parser, result register.
//
// Input channel: in_valid / in_stall carry one file byte per item (data_byte) and
// end_of_file, which marks the last byte of the file.
// Output channel: out_valid / out_stall carry one token per item: kind, value,
// current status and meta type, event-last flag and error code.
// Each input byte gives zero or one token. Matching signature bytes and the leading
// bytes of multi-byte fields give none; after an error bytes are swallowed up to
// end_of_file.
// Path: an accepted byte sits in the input register; the parser step then takes it
// and loads its token, if any, into the result register, which drives out_valid.
// Throughput: one byte per cycle while the output is not stalled; the parser state
// update is combinational logic per byte.
// Stall: while the result register holds an untaken token, the byte in the input
// register waits and in_stall rises once that register is also full; no token is
// lost or repeated.
// Reset: clears both registers and returns the parser to expecting "MThd". A byte
// with end_of_file set also returns the parser to that state after it is processed.
module midi_file_stream_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [31:0] token_value,
  output logic [7:0]  current_status,
  output logic [7:0]  current_meta_type,
  output logic        event_last,
  output logic [2:0]  error_code
);
  import mfsp_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eof;
  logic       out_free;
  logic       advance;
  logic       in_take;
  logic       emit;
  token_t     tok;
  token_t     res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  mfsp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (s1_byte),
    .end_of_file (s1_eof),
    .emit        (emit),
    .tok         (tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !advance);
    end
    if (in_take) begin
      s1_byte <= data_byte;
      s1_eof  <= end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && emit;
    end
    if (advance && emit) res <= tok;
  end

  assign token_kind        = res.kind;
  assign token_value       = res.value;
  assign current_status    = res.status;
  assign current_meta_type = res.meta;
  assign event_last        = res.last;
  assign error_code        = res.err;

endmodule
